// ===== rtl/pic_pkg.sv =====
// Shared types and codes for the eight-level interrupt controller.
// Used by pic_prio and programmable_interrupt_controller; depends on nothing.

package pic_pkg;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;
  localparam int OPCODE_W    = 3;

  // Item kinds carried on in_tuser
  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_READ  = 3'd1,
    OP_LINE  = 3'd2,
    OP_ACK1  = 3'd3,
    OP_ACK2  = 3'd4
  } opcode_t;

  // Position in the ICW sequence
  typedef enum logic [1:0] {
    INIT_ICW2  = 2'd0,
    INIT_ICW3  = 2'd1,
    INIT_ICW4  = 2'd2,
    INIT_READY = 2'd3
  } init_step_t;

  // Mode flag bit positions
  localparam int MF_LTIM = 0;
  localparam int MF_SNGL = 1;
  localparam int MF_IC4  = 2;
  localparam int MF_UPM  = 3;
  localparam int MF_AEOI = 4;
  localparam int MF_SFNM = 5;
  localparam int MF_W    = 6;

  // Operation flag bit positions
  localparam int OF_SMM  = 0;
  localparam int OF_RIS  = 1;
  localparam int OF_ROT  = 2;
  localparam int OF_POLL = 3;
  localparam int OF_W    = 4;

  // Level reported on an acknowledge with nothing pending
  localparam logic [2:0] SPURIOUS_LVL = 3'd7;

  // Result of the rotating priority search
  typedef struct packed {
    logic       nx_vld;   // a request would be served
    logic [2:0] nx_lvl;   // level served next
    logic       tis_vld;  // something counts as in service
    logic [2:0] tis_lvl;  // highest-priority level in service
  } prio_t;

endpackage

// ===== rtl/pic_prio.sv =====
// Rotating priority resolver: next level to serve and top in-service level.
// Depends on pic_pkg (prio_t).

module pic_prio (
  input  logic [7:0]     irr_i,
  input  logic [7:0]     imr_i,
  input  logic [7:0]     isr_i,
  input  logic           smm_i,
  input  logic           sfnm_i,
  input  logic [2:0]     base_i,
  output pic_pkg::prio_t prio_o
);

  logic [7:0]  req;
  logic [7:0]  blk;
  logic [15:0] req_dbl;
  logic [15:0] blk_dbl;
  logic [7:0]  req_rot;
  logic [7:0]  blk_rot;
  logic [7:0]  any_rot;
  logic        nx_hit;
  logic [2:0]  nx_idx;
  logic        tis_hit;
  logic [2:0]  tis_idx;

  assign req     = irr_i & ~imr_i;
  assign blk     = smm_i ? (isr_i & ~imr_i) : isr_i;
  assign req_dbl = {req, req} >> base_i;
  assign blk_dbl = {blk, blk} >> base_i;
  assign req_rot = req_dbl[7:0];
  assign blk_rot = blk_dbl[7:0];
  assign any_rot = req_rot | blk_rot;

  // lowest set bit of the rotated vectors, counted from the priority base
  always_comb begin
    nx_hit  = 1'b0;
    nx_idx  = 3'd0;
    tis_hit = 1'b0;
    tis_idx = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (!nx_hit && any_rot[i]) begin
        nx_hit = 1'b1;
        nx_idx = 3'(i);
      end
      if (!tis_hit && blk_rot[i]) begin
        tis_hit = 1'b1;
        tis_idx = 3'(i);
      end
    end
  end

  // an in-service level blocks everything below it; special fully nested
  // mode still lets a request at that same level through
  assign prio_o.nx_vld  = nx_hit && (!blk_rot[nx_idx] || (sfnm_i && req_rot[nx_idx]));
  assign prio_o.nx_lvl  = base_i + nx_idx;
  assign prio_o.tis_vld = tis_hit;
  assign prio_o.tis_lvl = base_i + tis_idx;

endmodule

// ===== rtl/programmable_interrupt_controller.sv =====
// Top level of the eight-level interrupt controller of the 8259A kind.
// Depends on pic_pkg and pic_prio.
//
// Usage:
//   Each word on the input stream is one event: a bus write, a bus read, a
//   request-line change, or the first or second acknowledge pulse. The kind
//   rides on in_tuser; A0, the write byte, the line number and its new level
//   ride on in_tdata. Every input word yields exactly one output word that
//   carries the read byte, acknowledged level or vector byte, the line-moved
//   flag, and the controller status (pending flag, pending level, 8086 mode)
//   as it stands after that event.
//   Latency: the result is registered and is on out_tdata in the cycle after
//   the input word is taken. Throughput: one word per cycle while out_tready
//   stays high; all decoding and both rotating priority searches sit between
//   the controller registers and the single output register.
//   Stall: while out_tready is low the output word holds, and in_tready is
//   high only while the output register is empty or its word is being taken,
//   so a new word is taken in the same cycle that the waiting one leaves.
//   Reset (rst_n low, synchronous): clear IRR, ISR, pin levels, priority
//   base, vector base, mode and command flags; set IMR to all ones; expect
//   ICW2 next; drop any waiting output word.

module programmable_interrupt_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [2:0] opcode
  input  logic [pic_pkg::OPCODE_W-1:0]    in_tuser,
  // [0] addr_bit, [8:1] write_byte, [11:9] irq_line, [12] irq_asserted, [15:13] zero
  input  logic [pic_pkg::IN_TDATA_W-1:0]  in_tdata,
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [7:0] data_out, [8] line_moved, [9] int_pending, [12:10] pending_level,
  // [13] vectoring_ok, [15:14] zero
  output logic [pic_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // controller registers
  logic [7:0]                       irr_r,  irr_nxt;
  logic [7:0]                       imr_r,  imr_nxt;
  logic [7:0]                       isr_r,  isr_nxt;
  logic [7:0]                       pin_r,  pin_nxt;
  logic [2:0]                       prio_r, prio_nxt;
  logic [4:0]                       vhi_r,  vhi_nxt;
  pic_pkg::init_step_t              init_r, init_nxt;
  logic [pic_pkg::MF_W-1:0]         mode_r, mode_nxt;
  logic [pic_pkg::OF_W-1:0]         ocw_r,  ocw_nxt;
  logic [2:0]                       ack_r,  ack_nxt;

  // output register
  logic                             out_valid_r;
  logic [pic_pkg::OUT_TDATA_W-1:0]  out_data_r;
  logic [pic_pkg::OUT_TDATA_W-1:0]  res_word;

  // unpacked input word
  logic                             in_fire;
  pic_pkg::opcode_t                 op;
  logic                             a0;
  logic [7:0]                       wb;
  logic [2:0]                       line;
  logic                             hi;

  logic [7:0]                       res_data;
  logic                             res_moved;
  logic [2:0]                       eoi_lvl;
  logic [7:0]                       take_bit;
  logic [7:0]                       ltim_fill;

  pic_pkg::prio_t                   cur_p;
  pic_pkg::prio_t                   nxt_p;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;

  assign op   = pic_pkg::opcode_t'(in_tuser);
  assign a0   = in_tdata[0];
  assign wb   = in_tdata[8:1];
  assign line = in_tdata[11:9];
  assign hi   = in_tdata[12];

  // priority view of the state before the event
  pic_prio u_prio_cur (
    .irr_i  (irr_r),
    .imr_i  (imr_r),
    .isr_i  (isr_r),
    .smm_i  (ocw_r[pic_pkg::OF_SMM]),
    .sfnm_i (mode_r[pic_pkg::MF_SFNM]),
    .base_i (prio_r),
    .prio_o (cur_p)
  );

  // level granted by an acknowledge or poll; level-triggered lines re-arm IRR
  assign take_bit  = 8'b1 << cur_p.nx_lvl;
  assign ltim_fill = mode_r[pic_pkg::MF_LTIM] ? pin_r : 8'h00;

  always_comb begin
    irr_nxt   = irr_r;
    imr_nxt   = imr_r;
    isr_nxt   = isr_r;
    pin_nxt   = pin_r;
    prio_nxt  = prio_r;
    vhi_nxt   = vhi_r;
    init_nxt  = init_r;
    mode_nxt  = mode_r;
    ocw_nxt   = ocw_r;
    ack_nxt   = ack_r;
    res_data  = 8'h00;
    res_moved = 1'b0;
    eoi_lvl   = wb[6] ? wb[2:0] : cur_p.tis_lvl;

    unique case (op)
      pic_pkg::OP_WRITE: begin
        if (!a0 && wb[4]) begin
          // ICW1: restart the init sequence, keep ICW4 bits only if IC4
          if (!wb[0]) begin
            mode_nxt = '0;
          end else begin
            mode_nxt = '0;
            mode_nxt[pic_pkg::MF_UPM]  = mode_r[pic_pkg::MF_UPM];
            mode_nxt[pic_pkg::MF_AEOI] = mode_r[pic_pkg::MF_AEOI];
            mode_nxt[pic_pkg::MF_SFNM] = mode_r[pic_pkg::MF_SFNM];
          end
          mode_nxt[pic_pkg::MF_LTIM] = wb[3];
          mode_nxt[pic_pkg::MF_SNGL] = wb[1];
          mode_nxt[pic_pkg::MF_IC4]  = wb[0];
          irr_nxt  = 8'h00;
          imr_nxt  = 8'h00;
          isr_nxt  = 8'h00;
          prio_nxt = 3'd0;
          ocw_nxt  = '0;
          init_nxt = pic_pkg::INIT_ICW2;
        end else if (a0) begin
          unique case (init_r)
            pic_pkg::INIT_ICW2: begin
              vhi_nxt = wb[7:3];
              if (!mode_r[pic_pkg::MF_SNGL]) begin
                init_nxt = pic_pkg::INIT_ICW3;
              end else if (mode_r[pic_pkg::MF_IC4]) begin
                init_nxt = pic_pkg::INIT_ICW4;
              end else begin
                init_nxt = pic_pkg::INIT_READY;
              end
            end
            pic_pkg::INIT_ICW3: begin
              init_nxt = mode_r[pic_pkg::MF_IC4] ? pic_pkg::INIT_ICW4 : pic_pkg::INIT_READY;
            end
            pic_pkg::INIT_ICW4: begin
              mode_nxt[pic_pkg::MF_UPM]  = wb[0];
              mode_nxt[pic_pkg::MF_AEOI] = wb[1];
              mode_nxt[pic_pkg::MF_SFNM] = wb[4];
              init_nxt = pic_pkg::INIT_READY;
            end
            pic_pkg::INIT_READY: begin
              imr_nxt = wb;
            end
            default: ;
          endcase
        end else if (wb[3]) begin
          // OCW3: special mask, poll, status-read select
          if (wb[6]) begin
            ocw_nxt[pic_pkg::OF_SMM] = wb[5];
          end
          if (wb[2]) begin
            ocw_nxt[pic_pkg::OF_POLL] = 1'b1;
          end else if (wb[1]) begin
            ocw_nxt[pic_pkg::OF_RIS] = wb[0];
          end
        end else begin
          // OCW2: EOI and rotation commands
          if (wb[5]) begin
            if (wb[6] || cur_p.tis_vld) begin
              isr_nxt[eoi_lvl] = 1'b0;
              if (wb[7]) begin
                prio_nxt = eoi_lvl + 3'd1;
              end
            end
          end else if (wb[7] && wb[6]) begin
            prio_nxt = wb[2:0] + 3'd1;
          end else if (wb[7]) begin
            ocw_nxt[pic_pkg::OF_ROT] = 1'b1;
          end else if (!wb[6]) begin
            ocw_nxt[pic_pkg::OF_ROT] = 1'b0;
          end
        end
      end

      pic_pkg::OP_READ: begin
        if (a0) begin
          res_data = imr_r;
        end else if (ocw_r[pic_pkg::OF_POLL]) begin
          // poll read acts as an acknowledge; nothing pending returns zero
          ocw_nxt[pic_pkg::OF_POLL] = 1'b0;
          if (cur_p.nx_vld) begin
            isr_nxt  = isr_r | take_bit;
            irr_nxt  = (irr_r & ~take_bit) | ltim_fill;
            res_data = {1'b1, 4'b0000, cur_p.nx_lvl};
          end
        end else begin
          res_data = ocw_r[pic_pkg::OF_RIS] ? isr_r : irr_r;
        end
      end

      pic_pkg::OP_LINE: begin
        pin_nxt[line] = hi;
        res_moved     = hi ^ pin_r[line];
        if (mode_r[pic_pkg::MF_LTIM]) begin
          irr_nxt[line] = hi;
        end else if (!hi) begin
          irr_nxt[line] = 1'b0;
        end else if (!pin_r[line]) begin
          irr_nxt[line] = 1'b1;
        end
      end

      pic_pkg::OP_ACK1: begin
        if (cur_p.nx_vld) begin
          isr_nxt = isr_r | take_bit;
          irr_nxt = (irr_r & ~take_bit) | ltim_fill;
          ack_nxt = cur_p.nx_lvl;
        end else begin
          ack_nxt = pic_pkg::SPURIOUS_LVL;
        end
        res_data = {5'b00000, ack_nxt};
      end

      pic_pkg::OP_ACK2: begin
        // auto EOI retires the top in-service level, rotating if armed
        if (mode_r[pic_pkg::MF_AEOI] && cur_p.tis_vld) begin
          isr_nxt[cur_p.tis_lvl] = 1'b0;
          if (ocw_r[pic_pkg::OF_ROT]) begin
            prio_nxt = cur_p.tis_lvl + 3'd1;
          end
        end
        res_data = {vhi_r, ack_r};
      end

      default: ;
    endcase
  end

  // priority view of the state after the event, for the status fields
  pic_prio u_prio_nxt (
    .irr_i  (irr_nxt),
    .imr_i  (imr_nxt),
    .isr_i  (isr_nxt),
    .smm_i  (ocw_nxt[pic_pkg::OF_SMM]),
    .sfnm_i (mode_nxt[pic_pkg::MF_SFNM]),
    .base_i (prio_nxt),
    .prio_o (nxt_p)
  );

  assign res_word = {2'b00,
                     mode_nxt[pic_pkg::MF_UPM],
                     nxt_p.nx_vld ? nxt_p.nx_lvl : 3'd0,
                     nxt_p.nx_vld,
                     res_moved,
                     res_data};

  // advance controller state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      irr_r  <= 8'h00;
      imr_r  <= 8'hFF;
      isr_r  <= 8'h00;
      pin_r  <= 8'h00;
      prio_r <= 3'd0;
      vhi_r  <= 5'd0;
      init_r <= pic_pkg::INIT_ICW2;
      mode_r <= '0;
      ocw_r  <= '0;
      ack_r  <= 3'd0;
    end else if (in_fire) begin
      irr_r  <= irr_nxt;
      imr_r  <= imr_nxt;
      isr_r  <= isr_nxt;
      pin_r  <= pin_nxt;
      prio_r <= prio_nxt;
      vhi_r  <= vhi_nxt;
      init_r <= init_nxt;
      mode_r <= mode_nxt;
      ocw_r  <= ocw_nxt;
      ack_r  <= ack_nxt;
    end
  end

  // output register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res_word;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // an accepted word always produces a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_tvalid)
    else $error("accepted word produced no result");

  // a reported pending level is requested and unmasked in the updated state
  a_pending_real: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (!out_tdata[9] ||
                 (irr_r[out_tdata[12:10]] && !imr_r[out_tdata[12:10]])))
    else $error("pending level not an unmasked request");

  // the status word never reports a level without the pending flag
  a_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (out_tdata[9] || out_tdata[12:10] == 3'd0))
    else $error("pending level set without pending flag");

  // a first acknowledge with a grant sets that level in service
  a_ack_sets_isr: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && op == pic_pkg::OP_ACK1 && cur_p.nx_vld) |=> isr_r[ack_r])
    else $error("granted level not in service");

endmodule

// ===== tb/sv/tb_programmable_interrupt_controller.sv =====
// Self-checking testbench for the eight-level interrupt controller: drives
// bus, request-line and acknowledge events and compares every status word
// against a cycle-free shadow of the controller. Needs pic_pkg and the RTL.

module tb_programmable_interrupt_controller;
  timeunit 1ns;
  timeprecision 1ps;

  // Command byte fields of the ICW and OCW writes
  localparam logic [7:0] CW1_NEED_CW4 = 8'h01;
  localparam logic [7:0] CW1_SINGLE   = 8'h02;
  localparam logic [7:0] CW1_LEVEL    = 8'h08;
  localparam logic [7:0] ICW1_SEL     = 8'h10;
  localparam logic [7:0] CW4_X86      = 8'h01;
  localparam logic [7:0] CW4_AUTO_EOI = 8'h02;
  localparam logic [7:0] CW4_NESTED   = 8'h10;
  localparam logic [7:0] OCW2_NONE    = 8'h00;
  localparam logic [7:0] CW2_END_INT  = 8'h20;
  localparam logic [7:0] OCW2_SL      = 8'h40;
  localparam logic [7:0] OCW2_ROT     = 8'h80;
  localparam logic [7:0] CW3_READ_ISR = 8'h01;
  localparam logic [7:0] OCW3_RR      = 8'h02;
  localparam logic [7:0] CW3_POLL_CMD = 8'h04;
  localparam logic [7:0] OCW3_SEL     = 8'h08;
  localparam logic [7:0] OCW3_SMM     = 8'h20;
  localparam logic [7:0] CW3_MASK_EN  = 8'h40;

  // Opcodes the controller does not decode
  localparam logic [2:0] OP_UNUSED_MIN = pic_pkg::OP_ACK2 + 3'd1;
  localparam logic [2:0] OP_UNUSED_MAX = 3'd7;

  localparam int NO_LEVEL    = 8;
  localparam int QUIET_LIMIT = 2000;
  localparam int STALL_LEN   = 300;
  localparam int REPORT_MAX  = 10;

  // Output word layout, lowest bit last
  typedef struct packed {
    logic [1:0] zero;
    logic       vectoring_ok;
    logic [2:0] pending_level;
    logic       int_pending;
    logic       line_moved;
    logic [7:0] data_out;
  } status_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [2:0]  in_tuser = '0;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  programmable_interrupt_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Shadow controller: the registers as they stand after every accepted
  // event, updated in acceptance order.
  // ---------------------------------------------------------------------
  logic [7:0]               irr, imr, isr, pins;
  logic [2:0]               prio_base, acked;
  logic [4:0]               vec_base;
  pic_pkg::init_step_t      step;
  logic [pic_pkg::MF_W-1:0] mode;
  logic [pic_pkg::OF_W-1:0] ops;

  status_word_t status_words[$];  // words the controller still owes
  int           failures = 0;
  int           words_sent = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           stall_seq = 0;
  int           stall_len = 0;

  function automatic void shadow_reset();
    irr = '0;
    imr = 8'hFF;
    isr = '0;
    pins = '0;
    prio_base = '0;
    acked = '0;
    vec_base = '0;
    step = pic_pkg::INIT_ICW2;
    mode = '0;
    ops = '0;
  endfunction

  // Rotating search for the level that would be served next.
  function automatic int next_served();
    logic [7:0] req;
    logic [7:0] blk;
    logic [2:0] lv;
    req = irr & ~imr;
    blk = ops[pic_pkg::OF_SMM] ? (isr & ~imr) : isr;
    for (int i = 0; i < 8; i++) begin
      lv = prio_base + 3'(i);
      // a level in service blocks itself and everything below it,
      // unless special fully nested mode lets it re-request
      if (blk[lv]) return (mode[pic_pkg::MF_SFNM] && req[lv]) ? int'(lv) : NO_LEVEL;
      if (req[lv]) return int'(lv);
    end
    return NO_LEVEL;
  endfunction

  function automatic int top_in_service();
    logic [7:0] cur;
    logic [2:0] lv;
    cur = ops[pic_pkg::OF_SMM] ? (isr & ~imr) : isr;
    for (int i = 0; i < 8; i++) begin
      lv = prio_base + 3'(i);
      if (cur[lv]) return int'(lv);
    end
    return NO_LEVEL;
  endfunction

  function automatic void take_level(input logic [2:0] lv);
    isr[lv] = 1'b1;
    irr[lv] = 1'b0;
    // level-triggered lines that are still high request again at once
    if (mode[pic_pkg::MF_LTIM]) irr = irr | pins;
  endfunction

  function automatic void clear_service(input logic [2:0] lv, input logic rot);
    isr[lv] = 1'b0;
    if (rot) prio_base = lv + 3'd1;
  endfunction

  function automatic void bus_write(input logic a0, input logic [7:0] v);
    logic [pic_pkg::MF_W-1:0] m;
    int                       t;
    if (!a0 && (v & ICW1_SEL) != 0) begin
      // ICW1: restart the init sequence, keep ICW4 modes only if IC4 set
      m = '0;
      if ((v & CW1_NEED_CW4) != 0) begin
        m[pic_pkg::MF_UPM]  = mode[pic_pkg::MF_UPM];
        m[pic_pkg::MF_AEOI] = mode[pic_pkg::MF_AEOI];
        m[pic_pkg::MF_SFNM] = mode[pic_pkg::MF_SFNM];
      end
      m[pic_pkg::MF_LTIM] = (v & CW1_LEVEL) != 0;
      m[pic_pkg::MF_SNGL] = (v & CW1_SINGLE) != 0;
      m[pic_pkg::MF_IC4]  = (v & CW1_NEED_CW4) != 0;
      mode = m;
      irr = '0;
      imr = '0;
      isr = '0;
      prio_base = '0;
      ops = '0;
      step = pic_pkg::INIT_ICW2;
    end else if (a0) begin
      case (step)
        pic_pkg::INIT_ICW2: begin
          vec_base = v[7:3];
          if (!mode[pic_pkg::MF_SNGL]) step = pic_pkg::INIT_ICW3;
          else step = mode[pic_pkg::MF_IC4] ? pic_pkg::INIT_ICW4 : pic_pkg::INIT_READY;
        end
        pic_pkg::INIT_ICW3:
          step = mode[pic_pkg::MF_IC4] ? pic_pkg::INIT_ICW4 : pic_pkg::INIT_READY;
        pic_pkg::INIT_ICW4: begin
          mode[pic_pkg::MF_UPM]  = (v & CW4_X86) != 0;
          mode[pic_pkg::MF_AEOI] = (v & CW4_AUTO_EOI) != 0;
          mode[pic_pkg::MF_SFNM] = (v & CW4_NESTED) != 0;
          step = pic_pkg::INIT_READY;
        end
        default: imr = v;
      endcase
    end else if ((v & OCW3_SEL) != 0) begin
      if ((v & CW3_MASK_EN) != 0) ops[pic_pkg::OF_SMM] = (v & OCW3_SMM) != 0;
      // a poll command overrides the register-read select
      if ((v & CW3_POLL_CMD) != 0) ops[pic_pkg::OF_POLL] = 1'b1;
      else if ((v & OCW3_RR) != 0) ops[pic_pkg::OF_RIS] = (v & CW3_READ_ISR) != 0;
    end else if ((v & CW2_END_INT) != 0) begin
      t = ((v & OCW2_SL) != 0) ? int'(v[2:0]) : top_in_service();
      if (t != NO_LEVEL) clear_service(3'(t), (v & OCW2_ROT) != 0);
    end else if ((v & OCW2_ROT) != 0 && (v & OCW2_SL) != 0) begin
      prio_base = v[2:0] + 3'd1;
    end else if ((v & OCW2_ROT) != 0) begin
      ops[pic_pkg::OF_ROT] = 1'b1;
    end else if ((v & OCW2_SL) == 0) begin
      ops[pic_pkg::OF_ROT] = 1'b0;
    end
  endfunction

  function automatic logic [7:0] bus_read(input logic a0);
    int lv;
    if (a0) return imr;
    if (ops[pic_pkg::OF_POLL]) begin
      ops[pic_pkg::OF_POLL] = 1'b0;
      lv = next_served();
      if (lv == NO_LEVEL) return 8'h00;
      take_level(3'(lv));
      return {1'b1, 4'b0, 3'(lv)};
    end
    return ops[pic_pkg::OF_RIS] ? isr : irr;
  endfunction

  // Apply one event to the shadow and return the word it must produce.
  function automatic status_word_t apply_event(input logic [2:0] op, input logic a0,
                                               input logic [7:0] wb, input logic [2:0] line,
                                               input logic hi);
    status_word_t w;
    int           lv;
    logic         was;
    w = '0;
    case (op)
      pic_pkg::OP_WRITE: bus_write(a0, wb);
      pic_pkg::OP_READ:  w.data_out = bus_read(a0);
      pic_pkg::OP_LINE: begin
        was = pins[line];
        w.line_moved = hi != was;
        pins[line] = hi;
        if (mode[pic_pkg::MF_LTIM]) irr[line] = hi;
        else if (!hi) irr[line] = 1'b0;
        else if (!was) irr[line] = 1'b1;
      end
      pic_pkg::OP_ACK1: begin
        lv = next_served();
        if (lv == NO_LEVEL) begin
          acked = pic_pkg::SPURIOUS_LVL;
        end else begin
          take_level(3'(lv));
          acked = 3'(lv);
        end
        w.data_out = {5'b0, acked};
      end
      pic_pkg::OP_ACK2: begin
        if (mode[pic_pkg::MF_AEOI]) begin
          lv = top_in_service();
          if (lv != NO_LEVEL) clear_service(3'(lv), ops[pic_pkg::OF_ROT]);
        end
        w.data_out = {vec_base, acked};
      end
      default: ;
    endcase
    lv = next_served();
    w.int_pending   = lv != NO_LEVEL;
    w.pending_level = (lv != NO_LEVEL) ? 3'(lv) : 3'd0;
    w.vectoring_ok  = mode[pic_pkg::MF_UPM];
    return w;
  endfunction

  // ---------------------------------------------------------------------
  // Sender: offer one word, hold it until taken, then advance the shadow.
  // ---------------------------------------------------------------------
  task automatic send_word(input logic [2:0] op, input logic a0, input logic [7:0] wb,
                           input logic [2:0] line, input logic hi);
    // insert random gaps before the word
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, hi, line, wb, a0};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    status_words.push_back(apply_event(op, a0, wb, line, hi));
    words_sent++;
  endtask

  // Fields a given opcode ignores still carry random bits.
  task automatic bus_wr(input logic a0, input logic [7:0] v);
    send_word(pic_pkg::OP_WRITE, a0, v, 3'($urandom), 1'($urandom));
  endtask

  task automatic bus_rd(input logic a0);
    send_word(pic_pkg::OP_READ, a0, 8'($urandom), 3'($urandom), 1'($urandom));
  endtask

  task automatic line_set(input logic [2:0] line, input logic hi);
    send_word(pic_pkg::OP_LINE, 1'($urandom), 8'($urandom), line, hi);
  endtask

  task automatic ack(input logic [2:0] op);
    send_word(op, 1'($urandom), 8'($urandom), 3'($urandom), 1'($urandom));
  endtask

  // Stop offering and hold until every owed word has come back.
  task automatic wait_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (status_words.size() != 0);
  endtask

  task automatic set_idling(input int snd, input int rcv);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random ready, plus long hold-offs on request.
  // ---------------------------------------------------------------------
  int stall_seen = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    if (stall_seq != stall_seen) begin
      stall_seen = stall_seq;
      stall_left = stall_len;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= $urandom_range(99, 0) >= recv_idle_pct;
    end
  end

  // ---------------------------------------------------------------------
  // Checker: compare each taken word with the oldest owed one.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    status_word_t got;
    status_word_t want;
    if (out_tvalid && out_tready) begin
      got = out_tdata;
      if (status_words.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX) $display("unexpected word %h", got);
      end else begin
        want = status_words.pop_front();
        if (got.data_out !== want.data_out || got.line_moved !== want.line_moved ||
            got.int_pending !== want.int_pending ||
            got.pending_level !== want.pending_level ||
            got.vectoring_ok !== want.vectoring_ok || got.zero !== want.zero) begin
          failures++;
          if (failures <= REPORT_MAX)
            $display("mismatch: data %h/%h moved %b/%b pend %b/%b lvl %0d/%0d upm %b/%b pad %b/%b",
                     want.data_out, got.data_out, want.line_moved, got.line_moved,
                     want.int_pending, got.int_pending, want.pending_level,
                     got.pending_level, want.vectoring_ok, got.vectoring_ok,
                     want.zero, got.zero);
        end
      end
    end
  end

  // Watchdog: end the run if neither side moves for too long.
  int quiet = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Events on a controller that has seen no ICW1 yet.
  task automatic test_before_init();
    send_word(OP_UNUSED_MAX, 1'b1, 8'hFF, 3'd7, 1'b1);
    bus_rd(1'b1);
    bus_rd(1'b0);
    bus_wr(1'b1, 8'h00);          // lands in ICW2 as after reset
    ack(pic_pkg::OP_ACK2);        // second pulse with no first one
    ack(pic_pkg::OP_ACK1);        // everything masked: spurious level
    line_set(3'd7, 1'b1);
  endtask

  // Single, level-triggered, with ICW4: 8086 mode, auto EOI, nested.
  task automatic test_init_modes();
    bus_wr(1'b0, ICW1_SEL | CW1_LEVEL | CW1_SINGLE | CW1_NEED_CW4);
    bus_wr(1'b1, 8'hF8);
    bus_wr(1'b1, CW4_X86 | CW4_AUTO_EOI | CW4_NESTED);
    bus_wr(1'b1, 8'h00);
  endtask

  // Poll, register reads, EOI flavors, rotation and special mask.
  task automatic test_commands();
    line_set(3'd0, 1'b1);
    bus_wr(1'b0, OCW3_SEL | CW3_POLL_CMD);
    bus_rd(1'b0);
    bus_wr(1'b0, OCW3_SEL | OCW3_RR | CW3_READ_ISR);
    bus_rd(1'b0);
    bus_wr(1'b0, OCW2_SL);      // no operation
    bus_wr(1'b0, CW2_END_INT);
    bus_wr(1'b0, CW2_END_INT);  // nothing left in service
    bus_wr(1'b0, OCW3_SEL | CW3_MASK_EN | OCW3_SMM);
    bus_wr(1'b0, OCW2_ROT | OCW2_SL | 8'h06);
    bus_wr(1'b0, OCW2_ROT);
  endtask

  // Acknowledge pair with auto EOI and rotation, then an empty poll.
  task automatic test_ack_cycle();
    ack(pic_pkg::OP_ACK1);
    ack(pic_pkg::OP_ACK2);
    bus_wr(1'b0, OCW2_ROT | CW2_END_INT | OCW2_SL | 8'h07);
    bus_wr(1'b0, OCW2_NONE);
    bus_wr(1'b0, OCW3_SEL | CW3_MASK_EN);
    line_set(3'd0, 1'b0);
    line_set(3'd7, 1'b0);
    bus_wr(1'b0, OCW3_SEL | CW3_POLL_CMD);
    bus_rd(1'b0);
    send_word(OP_UNUSED_MIN, 1'b0, 8'h00, 3'd0, 1'b0);
  endtask

  // One random event, mostly well formed.
  task automatic random_event();
    int         r;
    logic [7:0] b;
    r = $urandom_range(99, 0);
    b = 8'($urandom);
    if (r < 5) begin
      // full init sequence with random modes, then a sparse mask
      bus_wr(1'b0, b | ICW1_SEL);
      while (step != pic_pkg::INIT_READY) bus_wr(1'b1, 8'($urandom));
      bus_wr(1'b1, 8'($urandom) & 8'($urandom));
    end else if (r < 35) begin
      line_set(3'($urandom), 1'($urandom));
    end else if (r < 52) begin
      ack(pic_pkg::OP_ACK1);
      ack(pic_pkg::OP_ACK2);
    end else if (r < 58) begin
      ack($urandom_range(1, 0) ? pic_pkg::OP_ACK1 : pic_pkg::OP_ACK2);
    end else if (r < 66) begin
      bus_rd(1'($urandom));
    end else if (r < 76) begin
      bus_wr(1'b0, b & ~(ICW1_SEL | OCW3_SEL));
    end else if (r < 83) begin
      bus_wr(1'b0, (b & ~ICW1_SEL) | OCW3_SEL);
    end else if (r < 89) begin
      bus_wr(1'b0, (b & ~ICW1_SEL) | OCW3_SEL | CW3_POLL_CMD);
      bus_rd(1'b0);
    end else if (r < 94) begin
      bus_wr(1'b1, 8'($urandom) & 8'($urandom));
    end else if (r < 97) begin
      send_word(3'($urandom_range(OP_UNUSED_MAX, OP_UNUSED_MIN)), 1'($urandom),
                b, 3'($urandom), 1'($urandom));
    end else begin
      // noise: any opcode with any fields
      send_word(3'($urandom), 1'($urandom), b, 3'($urandom), 1'($urandom));
    end
  endtask

  task automatic test_random_traffic(input int count);
    int stop_at;
    stop_at = words_sent + count;
    while (words_sent < stop_at) random_event();
  endtask

  // Hold the receiver off while the sender keeps pushing, then drain.
  task automatic test_output_backpressure();
    int saved;
    saved = send_idle_pct;
    send_idle_pct = 0;
    stall_len <= STALL_LEN;
    stall_seq <= stall_seq + 1;
    test_random_traffic(30);
    wait_results();
    send_idle_pct = saved;
  endtask

  initial begin
    shadow_reset();
    set_idling(35, 62);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_before_init();
    test_init_modes();
    test_commands();
    test_ack_cycle();
    test_random_traffic(350);
    test_output_backpressure();

    set_idling(62, 35);
    test_random_traffic(350);
    wait_results();  // sender holds until everything owed has come back

    set_idling(0, 0);
    test_random_traffic(350);

    wait_results();
    repeat (4) @(posedge clk);
    if (failures == 0 && status_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== programmable_interrupt_controller.f =====
rtl/pic_pkg.sv
rtl/pic_prio.sv
rtl/programmable_interrupt_controller.sv
tb/sv/tb_programmable_interrupt_controller.sv
